// ===== sv/fnv1a_dual_lane_uuid_deriver_assert.svh =====
// Assertion macros shared by the deriver RTL.
`ifndef FNV1A_DUAL_LANE_UUID_DERIVER_ASSERT_SVH
`define FNV1A_DUAL_LANE_UUID_DERIVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FNVU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fnvu: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FNVU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fnvu: next-cycle check failed");

`endif

// ===== sv/fnvu_pkg.sv =====
`default_nettype none

package fnvu_pkg;

    localparam int unsigned HASH_W    = 64;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [HASH_W-1:0] FNV_OFFSET_BASIS = 64'hCBF2_9CE4_8422_2325;

    // Version nibble in bits 55:52 of the first word, variant in bits 7:6 of the second.
    localparam logic [3:0] UUID_VERSION = 4'b0101;
    localparam logic [1:0] UUID_VARIANT = 2'b10;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEED_FIRST  = 1'b0,
        CFG_SEED_SECOND = 1'b1
    } cfg_index_t;

    // Multiply by the FNV-64 prime 2^40 + 2^8 + 0xB3, written as a shift-add.
    function automatic logic [HASH_W-1:0] mul_fnv_prime(input logic [HASH_W-1:0] x);
        mul_fnv_prime = (x << 40) + (x << 8) + (x << 7) + (x << 5)
                      + (x << 4) + (x << 1) + x;
    endfunction

    // One FNV-1a round: xor the byte in, then multiply by the prime.
    function automatic logic [HASH_W-1:0] fnv1a_round(
        input logic [HASH_W-1:0] h,
        input logic [BYTE_W-1:0] b
    );
        fnv1a_round = mul_fnv_prime(h ^ {{(HASH_W-BYTE_W){1'b0}}, b});
    endfunction

    function automatic logic [HASH_W-1:0] force_version(input logic [HASH_W-1:0] h);
        force_version = {h[63:56], UUID_VERSION, h[51:0]};
    endfunction

    function automatic logic [HASH_W-1:0] force_variant(input logic [HASH_W-1:0] h);
        force_variant = {h[63:8], UUID_VARIANT, h[5:0]};
    endfunction

endpackage

`default_nettype wire

// ===== sv/fnvu_byte_if.sv =====
`default_nettype none

// Request channel carrying one identifier byte per request.
interface fnvu_byte_if;
    logic                         valid;
    logic                         ready;
    logic [fnvu_pkg::BYTE_W-1:0]  data_byte;
    logic                         byte_present;
    logic                         last;

    modport source (output valid, output data_byte, output byte_present, output last,
                    input ready);
    modport sink   (input valid, input data_byte, input byte_present, input last,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/fnvu_uuid_if.sv =====
`default_nettype none

// Request channel carrying one derived UUID as two 64-bit words.
interface fnvu_uuid_if;
    logic                         valid;
    logic                         ready;
    logic [fnvu_pkg::HASH_W-1:0]  uuid_first_word;
    logic [fnvu_pkg::HASH_W-1:0]  uuid_second_word;

    modport source (output valid, output uuid_first_word, output uuid_second_word,
                    input ready);
    modport sink   (input valid, input uuid_first_word, input uuid_second_word,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/fnv1a_dual_lane_uuid_deriver.sv =====
// Dual-lane FNV-1a 64-bit name-based UUID deriver.
// The name_bytes channel takes one identifier byte per request; byte_present
// selects whether the byte is hashed, and last closes the identifier. The
// request carrying last produces one request on the uuid channel: the first
// lane hash with version 0101 in bits 55:52 and the second lane hash with
// variant 10 in bits 7:6. Both lanes then restart from their seeds.
// The configuration port writes seed_first (index 0) or seed_second (index 1);
// a write also restarts that lane at once. Write seeds only while idle.
// Throughput is one byte per cycle while the output register is free or being
// drained; each lane updates through one shift-add multiply by the sparse FNV
// prime. The output register shows the UUID in the cycle after the last byte.
// Reset loads both seeds and lanes with the FNV offset basis and empties the
// output register. While a UUID waits on a stalled receiver, name_bytes stays
// ready only in the cycle the receiver takes the pending UUID.
`default_nettype none

`include "fnv1a_dual_lane_uuid_deriver_assert.svh"

module fnv1a_dual_lane_uuid_deriver (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [fnvu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [fnvu_pkg::HASH_W-1:0]       cfg_data,
    fnvu_byte_if.sink                              name_bytes,
    fnvu_uuid_if.source                            uuid
);

    logic [fnvu_pkg::HASH_W-1:0] seed_first_reg,  seed_first_next;
    logic [fnvu_pkg::HASH_W-1:0] seed_second_reg, seed_second_next;
    logic [fnvu_pkg::HASH_W-1:0] lane_first_reg,  lane_first_next;
    logic [fnvu_pkg::HASH_W-1:0] lane_second_reg, lane_second_next;
    logic                        out_valid_reg,   out_valid_next;
    logic [fnvu_pkg::HASH_W-1:0] out_first_reg,   out_first_next;
    logic [fnvu_pkg::HASH_W-1:0] out_second_reg,  out_second_next;

    logic                        accept;
    logic [fnvu_pkg::HASH_W-1:0] hashed_first;
    logic [fnvu_pkg::HASH_W-1:0] hashed_second;

    // The output register frees up whenever it is empty or being drained.
    assign name_bytes.ready = !out_valid_reg || uuid.ready;
    assign accept           = name_bytes.valid && name_bytes.ready;

    assign uuid.valid            = out_valid_reg;
    assign uuid.uuid_first_word  = out_first_reg;
    assign uuid.uuid_second_word = out_second_reg;

    // Both lanes hash the same byte in parallel.
    always_comb
    begin
        hashed_first  = lane_first_reg;
        hashed_second = lane_second_reg;
        if (name_bytes.byte_present)
        begin
            hashed_first  = fnvu_pkg::fnv1a_round(lane_first_reg,  name_bytes.data_byte);
            hashed_second = fnvu_pkg::fnv1a_round(lane_second_reg, name_bytes.data_byte);
        end
    end

    // Lane, seed and output register updates.
    always_comb
    begin
        seed_first_next  = seed_first_reg;
        seed_second_next = seed_second_reg;
        lane_first_next  = lane_first_reg;
        lane_second_next = lane_second_reg;
        out_valid_next   = out_valid_reg && !uuid.ready;
        out_first_next   = out_first_reg;
        out_second_next  = out_second_reg;

        if (accept)
        begin
            if (name_bytes.last)
            begin
                out_valid_next   = 1'b1;
                out_first_next   = fnvu_pkg::force_version(hashed_first);
                out_second_next  = fnvu_pkg::force_variant(hashed_second);
                lane_first_next  = seed_first_reg;
                lane_second_next = seed_second_reg;
            end
            else
            begin
                lane_first_next  = hashed_first;
                lane_second_next = hashed_second;
            end
        end

        // A seed write restarts its lane and drops any partial hash.
        if (cfg_we)
        begin
            unique case (cfg_index)
                fnvu_pkg::CFG_SEED_FIRST:
                begin
                    seed_first_next = cfg_data;
                    lane_first_next = cfg_data;
                end
                fnvu_pkg::CFG_SEED_SECOND:
                begin
                    seed_second_next = cfg_data;
                    lane_second_next = cfg_data;
                end
                default:
                begin
                    seed_first_next = seed_first_reg;
                end
            endcase
        end
    end

    // Control and hash state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_first_reg  <= fnvu_pkg::FNV_OFFSET_BASIS;
            seed_second_reg <= fnvu_pkg::FNV_OFFSET_BASIS;
            lane_first_reg  <= fnvu_pkg::FNV_OFFSET_BASIS;
            lane_second_reg <= fnvu_pkg::FNV_OFFSET_BASIS;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            seed_first_reg  <= seed_first_next;
            seed_second_reg <= seed_second_next;
            lane_first_reg  <= lane_first_next;
            lane_second_reg <= lane_second_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Output payload needs no reset.
    always_ff @(posedge clk)
    begin
        out_first_reg  <= out_first_next;
        out_second_reg <= out_second_next;
    end

    // Checks on the result format, the output handshake and the lane restart.
    `FNVU_ASSERT_SAME(a_version_set, clk, rst_n, uuid.valid,
        uuid.uuid_first_word[55:52] == fnvu_pkg::UUID_VERSION)
    `FNVU_ASSERT_SAME(a_variant_set, clk, rst_n, uuid.valid,
        uuid.uuid_second_word[7:6] == fnvu_pkg::UUID_VARIANT)
    `FNVU_ASSERT_NEXT(a_last_gives_uuid, clk, rst_n, accept && name_bytes.last,
        uuid.valid)
    `FNVU_ASSERT_NEXT(a_last_restarts_lanes, clk, rst_n,
        accept && name_bytes.last && !cfg_we,
        lane_first_reg == seed_first_reg && lane_second_reg == seed_second_reg)
    `FNVU_ASSERT_SAME(a_no_accept_when_full, clk, rst_n, uuid.valid && !uuid.ready,
        !name_bytes.ready)

endmodule

`default_nettype wire

// ===== tb/fnv1a_dual_lane_uuid_deriver_tb.sv =====
`timescale 1ns / 100ps

module fnv1a_dual_lane_uuid_deriver_tb;

    localparam logic [fnvu_pkg::HASH_W-1:0] FNV_PRIME_64  = 64'd1099511628211;
    localparam logic [fnvu_pkg::HASH_W-1:0] VERSION_CLEAR = 64'hFF0F_FFFF_FFFF_FFFF;
    localparam logic [fnvu_pkg::HASH_W-1:0] VERSION_SET   = 64'h0050_0000_0000_0000;
    localparam logic [fnvu_pkg::HASH_W-1:0] VARIANT_CLEAR = 64'hFFFF_FFFF_FFFF_FF3F;
    localparam logic [fnvu_pkg::HASH_W-1:0] VARIANT_SET   = 64'h0000_0000_0000_0080;
    localparam logic [fnvu_pkg::HASH_W-1:0] ALL_ONES      = {fnvu_pkg::HASH_W{1'b1}};
    localparam int                          SETTLE_CYCLES = 3;
    localparam int                          DRAIN_LIMIT   = 2000;

    typedef struct packed {
        logic [fnvu_pkg::HASH_W-1:0] first_word;
        logic [fnvu_pkg::HASH_W-1:0] second_word;
    } uuid_words_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [fnvu_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [fnvu_pkg::HASH_W-1:0]    cfg_data;

    fnvu_byte_if name_bytes_ch ();
    fnvu_uuid_if uuid_ch ();

    fnv1a_dual_lane_uuid_deriver dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .name_bytes (name_bytes_ch),
        .uuid       (uuid_ch)
    );

    // Predicted seeds and running lane hashes.
    logic [fnvu_pkg::HASH_W-1:0] first_seed;
    logic [fnvu_pkg::HASH_W-1:0] second_seed;
    logic [fnvu_pkg::HASH_W-1:0] first_lane;
    logic [fnvu_pkg::HASH_W-1:0] second_lane;

    uuid_words_t expected_uuids[$];

    int src_idle_pct;
    int sink_idle_pct;
    int error_count;
    int items_sent;
    int bytes_hashed;
    int uuids_checked;
    int seed_writes;

    // Free-running clock, 12 ns period.
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // One FNV-1a round on a 64-bit lane.
    function automatic logic [fnvu_pkg::HASH_W-1:0] fnv1a_mix(
        input logic [fnvu_pkg::HASH_W-1:0] h,
        input logic [fnvu_pkg::BYTE_W-1:0] b
    );
        return (h ^ {{(fnvu_pkg::HASH_W-fnvu_pkg::BYTE_W){1'b0}}, b}) * FNV_PRIME_64;
    endfunction

    // Lane state after hashing a domain prefix from the offset basis.
    function automatic logic [fnvu_pkg::HASH_W-1:0] hash_prefix(input string prefix);
        logic [fnvu_pkg::HASH_W-1:0] h;
        h = fnvu_pkg::FNV_OFFSET_BASIS;
        for (int i = 0; i < prefix.len(); i++)
        begin
            h = fnv1a_mix(h, prefix[i]);
        end
        return h;
    endfunction

    // Send one request and update the lane prediction once it is accepted.
    task automatic send_name_byte(input logic [fnvu_pkg::BYTE_W-1:0] b, input logic present,
                                  input logic is_last);
        uuid_words_t words;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            name_bytes_ch.valid <= 1'b0;
            @(posedge clk);
        end
        name_bytes_ch.valid        <= 1'b1;
        name_bytes_ch.data_byte    <= b;
        name_bytes_ch.byte_present <= present;
        name_bytes_ch.last         <= is_last;
        @(posedge clk);
        while (!name_bytes_ch.ready)
        begin
            @(posedge clk);
        end
        if (present)
        begin
            first_lane  = fnv1a_mix(first_lane, b);
            second_lane = fnv1a_mix(second_lane, b);
            bytes_hashed++;
        end
        if (is_last)
        begin
            words.first_word  = (first_lane & VERSION_CLEAR) | VERSION_SET;
            words.second_word = (second_lane & VARIANT_CLEAR) | VARIANT_SET;
            expected_uuids.push_back(words);
            first_lane  = first_seed;
            second_lane = second_seed;
        end
        if (present || is_last)
        begin
            items_sent++;
        end
    endtask

    // Write a seed once the block has gone quiet; the lane restarts from it.
    task automatic write_seed(input fnvu_pkg::cfg_index_t idx,
                              input logic [fnvu_pkg::HASH_W-1:0] value);
        name_bytes_ch.valid <= 1'b0;
        while (expected_uuids.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == fnvu_pkg::CFG_SEED_FIRST)
        begin
            first_seed = value;
            first_lane = value;
        end
        else
        begin
            second_seed = value;
            second_lane = value;
        end
        seed_writes++;
    endtask

    // Offset-basis seeds from reset: empty identifier, one byte, a short string.
    task automatic test_reset_seeds();
        send_name_byte(8'h00, 1'b0, 1'b1);
        send_name_byte(8'h61, 1'b1, 1'b1);
        send_name_byte(8'h61, 1'b1, 1'b0);
        send_name_byte(8'h62, 1'b1, 1'b0);
        send_name_byte(8'h63, 1'b1, 1'b1);
    endtask

    // Byte extremes, ignored idle requests and a bare terminator after bytes.
    task automatic test_field_extremes();
        send_name_byte(8'h00, 1'b1, 1'b0);
        send_name_byte(8'hFF, 1'b1, 1'b1);
        send_name_byte(8'hFF, 1'b0, 1'b0);
        send_name_byte(8'h00, 1'b1, 1'b0);
        send_name_byte(8'hA5, 1'b0, 1'b0);
        send_name_byte(8'h5A, 1'b0, 1'b1);
        send_name_byte(8'hFF, 1'b1, 1'b0);
        send_name_byte(8'hFF, 1'b1, 1'b1);
    endtask

    // Seeds at zero, at all ones, at domain-prefix states, and a write that
    // drops a partial hash in one lane only.
    task automatic test_seed_extremes();
        write_seed(fnvu_pkg::CFG_SEED_FIRST, '0);
        write_seed(fnvu_pkg::CFG_SEED_SECOND, '0);
        send_name_byte(8'h00, 1'b0, 1'b1);
        send_name_byte(8'h00, 1'b1, 1'b1);
        write_seed(fnvu_pkg::CFG_SEED_FIRST, ALL_ONES);
        write_seed(fnvu_pkg::CFG_SEED_SECOND, ALL_ONES);
        send_name_byte(8'h00, 1'b0, 1'b1);
        send_name_byte(8'hFF, 1'b1, 1'b1);
        write_seed(fnvu_pkg::CFG_SEED_FIRST, hash_prefix("display-a:"));
        write_seed(fnvu_pkg::CFG_SEED_SECOND, hash_prefix("display-b:"));
        send_name_byte(8'h31, 1'b1, 1'b0);
        send_name_byte(8'h32, 1'b1, 1'b0);
        write_seed(fnvu_pkg::CFG_SEED_FIRST, hash_prefix("display-a:"));
        send_name_byte(8'h33, 1'b1, 1'b1);
    endtask

    // Random identifiers with random seeds, idle noise and both terminator forms.
    task automatic test_random_identifiers(input int src_pct, input int sink_pct,
                                           input int item_goal);
        int goal;
        int id_len;
        goal          = items_sent + item_goal;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        write_seed(fnvu_pkg::CFG_SEED_FIRST, {$urandom, $urandom});
        write_seed(fnvu_pkg::CFG_SEED_SECOND, {$urandom, $urandom});
        while (items_sent < goal)
        begin
            // Occasionally reseed a lane between identifiers.
            if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: write_seed(fnvu_pkg::CFG_SEED_FIRST, {$urandom, $urandom});
                    1: write_seed(fnvu_pkg::CFG_SEED_SECOND, {$urandom, $urandom});
                    2: write_seed(fnvu_pkg::CFG_SEED_FIRST,
                                  ($urandom_range(0, 1) != 0) ? ALL_ONES : '0);
                    default: write_seed(fnvu_pkg::CFG_SEED_SECOND,
                                        fnvu_pkg::FNV_OFFSET_BASIS);
                endcase
            end
            if ($urandom_range(0, 3) == 0)
                id_len = $urandom_range(0, 2);
            else
                id_len = $urandom_range(3, 16);
            for (int i = 0; i < id_len; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_name_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                end
                send_name_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            end
            if ($urandom_range(0, 2) == 0)
                send_name_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            else
                send_name_byte(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        end
    endtask

    // Receiver: check each accepted UUID, then pick the next ready at random.
    initial
    begin
        uuid_words_t want;
        uuid_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && uuid_ch.valid && uuid_ch.ready)
            begin
                if (expected_uuids.size() == 0)
                begin
                    $error("UUID with none expected: %h %h",
                           uuid_ch.uuid_first_word, uuid_ch.uuid_second_word);
                    error_count++;
                end
                else
                begin
                    want = expected_uuids.pop_front();
                    if (uuid_ch.uuid_first_word !== want.first_word)
                    begin
                        $error("uuid_first_word: expected %h, actual %h",
                               want.first_word, uuid_ch.uuid_first_word);
                        error_count++;
                    end
                    if (uuid_ch.uuid_second_word !== want.second_word)
                    begin
                        $error("uuid_second_word: expected %h, actual %h",
                               want.second_word, uuid_ch.uuid_second_word);
                        error_count++;
                    end
                    uuids_checked++;
                end
            end
            uuid_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Test sequence.
    initial
    begin
        int drain_cycles;
        rst_n                      <= 1'b0;
        cfg_we                     <= 1'b0;
        cfg_index                  <= fnvu_pkg::CFG_SEED_FIRST;
        cfg_data                   <= '0;
        name_bytes_ch.valid        <= 1'b0;
        name_bytes_ch.data_byte    <= '0;
        name_bytes_ch.byte_present <= 1'b0;
        name_bytes_ch.last         <= 1'b0;
        first_seed    = fnvu_pkg::FNV_OFFSET_BASIS;
        second_seed   = fnvu_pkg::FNV_OFFSET_BASIS;
        first_lane    = fnvu_pkg::FNV_OFFSET_BASIS;
        second_lane   = fnvu_pkg::FNV_OFFSET_BASIS;
        src_idle_pct  = 23;
        sink_idle_pct = 55;
        error_count   = 0;
        items_sent    = 0;
        bytes_hashed  = 0;
        uuids_checked = 0;
        seed_writes   = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_seeds();
        test_field_extremes();
        test_seed_extremes();
        test_random_identifiers(23, 55, 170);
        test_random_identifiers(55, 23, 170);
        test_random_identifiers(0, 0, 170);

        // Let the last UUIDs come out, then wait out the settle time for stragglers.
        name_bytes_ch.valid <= 1'b0;
        drain_cycles = 0;
        while (expected_uuids.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_uuids.size() != 0)
        begin
            $error("%0d expected UUIDs never arrived", expected_uuids.size());
            error_count++;
        end

        $display("Sent %0d requests (%0d hashed bytes) and checked %0d UUIDs.",
                 items_sent, bytes_hashed, uuids_checked);
        $display("Seeds were rewritten %0d times under three idle patterns.", seed_writes);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/fnvu_pkg.sv
sv/fnvu_byte_if.sv
sv/fnvu_uuid_if.sv
sv/fnv1a_dual_lane_uuid_deriver.sv
tb/fnv1a_dual_lane_uuid_deriver_tb.sv
